// ----- design/rast_pkg.sv -----
package rast_pkg;

	// Width of every coordinate field on the channels
	localparam int unsigned PORT_W = 8;

	// Opcodes of a command transaction
	localparam logic OPC_LOAD = 1'b0;
	localparam logic OPC_STEP = 1'b1;

	// Direction codes of the minor axis
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd3;

	// One emitted pixel
	typedef struct packed {
		logic [PORT_W-1:0] pixel_x;
		logic [PORT_W-1:0] pixel_y;
		logic              pixel_color;
		logic              last_pixel;
	} pixel_t;

endpackage

// ----- design/rast_cmd_if.sv -----
interface rast_cmd_if;

	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [rast_pkg::PORT_W-1:0]      x_start;
	logic [rast_pkg::PORT_W-1:0]      y_start;
	logic [rast_pkg::PORT_W-1:0]      x_end;
	logic [rast_pkg::PORT_W-1:0]      y_end;
	logic                             pen_color;

	modport source (
		output valid, opcode, x_start, y_start, x_end, y_end, pen_color,
		input  ready
	);

	modport sink (
		input  valid, opcode, x_start, y_start, x_end, y_end, pen_color,
		output ready
	);

endinterface

// ----- design/rast_pix_if.sv -----
interface rast_pix_if;

	logic                             valid;
	logic                             ready;
	logic [rast_pkg::PORT_W-1:0]      pixel_x;
	logic [rast_pkg::PORT_W-1:0]      pixel_y;
	logic                             pixel_color;
	logic                             last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready
	);

endinterface

// ----- design/rast_core.sv -----
module rast_core #(
	parameter int unsigned COORD_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic                  opcode,
	input  logic [COORD_W-1:0]    x_start,
	input  logic [COORD_W-1:0]    y_start,
	input  logic [COORD_W-1:0]    x_end,
	input  logic [COORD_W-1:0]    y_end,
	input  logic                  pen_color,
	output logic                  emit,
	output rast_pkg::pixel_t      pix
);

	localparam int unsigned ERR_W = COORD_W + 1;

	logic               busy_q;
	logic               steep_q;
	logic [COORD_W-1:0] major_pos_q;
	logic [COORD_W-1:0] major_stop_q;
	logic [COORD_W-1:0] minor_pos_q;
	logic [1:0]         minor_step_q;
	logic [COORD_W-1:0] major_span_q;
	logic [COORD_W-1:0] minor_span_q;
	logic [ERR_W-1:0]   err_acc_q;
	logic               line_color_q;

	logic               is_load;
	logic               is_step;
	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;
	logic               ld_steep;
	logic [COORD_W-1:0] ma0;
	logic [COORD_W-1:0] ma1;
	logic [COORD_W-1:0] mi0;
	logic [COORD_W-1:0] mi1;
	logic [COORD_W-1:0] ld_major_pos;
	logic [COORD_W-1:0] ld_major_stop;
	logic [COORD_W-1:0] ld_minor_pos;
	logic [COORD_W-1:0] ld_minor_end;
	logic [1:0]         ld_dir;

	logic               last;
	logic [ERR_W-1:0]   err_sum;
	logic [ERR_W-1:0]   err_thr;
	logic               err_hit;
	logic [ERR_W-1:0]   err_next;
	logic [COORD_W-1:0] minor_next;

	assign is_load = take && (opcode == rast_pkg::OPC_LOAD);
	assign is_step = take && (opcode == rast_pkg::OPC_STEP);

	// Pick the major axis and order endpoints so the major coordinate counts up
	always_comb begin
		dx       = (x_start >= x_end) ? (x_start - x_end) : (x_end - x_start);
		dy       = (y_start >= y_end) ? (y_start - y_end) : (y_end - y_start);
		ld_steep = (dx < dy);
		if (ld_steep) begin
			ma0 = y_start;
			ma1 = y_end;
			mi0 = x_start;
			mi1 = x_end;
		end else begin
			ma0 = x_start;
			ma1 = x_end;
			mi0 = y_start;
			mi1 = y_end;
		end
		if (ma0 > ma1) begin
			ld_major_pos  = ma1;
			ld_major_stop = ma0;
			ld_minor_pos  = mi1;
			ld_minor_end  = mi0;
		end else begin
			ld_major_pos  = ma0;
			ld_major_stop = ma1;
			ld_minor_pos  = mi0;
			ld_minor_end  = mi1;
		end
		priority if (ld_minor_end > ld_minor_pos) begin
			ld_dir = rast_pkg::DIR_UP;
		end else if (ld_minor_end < ld_minor_pos) begin
			ld_dir = rast_pkg::DIR_DOWN;
		end else begin
			ld_dir = rast_pkg::DIR_NONE;
		end
	end

	// Advance the error term and the minor coordinate for one pixel
	always_comb begin
		last    = (major_pos_q == major_stop_q);
		err_sum = err_acc_q + ERR_W'(minor_span_q) + ERR_W'(1);
		err_thr = ERR_W'(major_span_q) + ERR_W'(1);
		err_hit = (err_sum >= err_thr);
		err_next   = err_hit ? (err_sum - err_thr) : err_sum;
		minor_next = minor_pos_q;
		if (err_hit) begin
			unique case (minor_step_q)
				rast_pkg::DIR_UP:   minor_next = minor_pos_q + COORD_W'(1);
				rast_pkg::DIR_DOWN: minor_next = minor_pos_q - COORD_W'(1);
				default:            minor_next = minor_pos_q;
			endcase
		end
	end

	// Drive the pixel for the current step
	assign emit = is_step && busy_q;

	always_comb begin
		if (steep_q) begin
			pix.pixel_x = rast_pkg::PORT_W'(minor_pos_q);
			pix.pixel_y = rast_pkg::PORT_W'(major_pos_q);
		end else begin
			pix.pixel_x = rast_pkg::PORT_W'(major_pos_q);
			pix.pixel_y = rast_pkg::PORT_W'(minor_pos_q);
		end
		pix.pixel_color = line_color_q;
		pix.last_pixel  = last;
	end

	// Hold the line state; load replaces it, step walks it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			steep_q      <= 1'b0;
			major_pos_q  <= '0;
			major_stop_q <= '0;
			minor_pos_q  <= '0;
			minor_step_q <= rast_pkg::DIR_NONE;
			major_span_q <= '0;
			minor_span_q <= '0;
			err_acc_q    <= '0;
			line_color_q <= 1'b0;
		end else if (is_load) begin
			busy_q       <= 1'b1;
			steep_q      <= ld_steep;
			major_pos_q  <= ld_major_pos;
			major_stop_q <= ld_major_stop;
			minor_pos_q  <= ld_minor_pos;
			minor_step_q <= ld_dir;
			major_span_q <= ld_steep ? dy : dx;
			minor_span_q <= ld_steep ? dx : dy;
			err_acc_q    <= '0;
			line_color_q <= pen_color;
		end else if (emit) begin
			err_acc_q   <= err_next;
			minor_pos_q <= minor_next;
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				major_pos_q <= major_pos_q + COORD_W'(1);
			end
		end
	end

endmodule

// ----- design/rast_out_stage.sv -----
module rast_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  rast_pkg::pixel_t    din,
	input  logic                drain,
	output logic                valid,
	output logic                free,
	output rast_pkg::pixel_t    dout
);

	logic             valid_q;
	rast_pkg::pixel_t data_q;

	// Room for a new pixel when empty or when the held one leaves this cycle
	assign free  = !valid_q || drain;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (drain) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the pixel payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

// ----- design/line_rasterizer_unit.sv -----
// Line rasterizer: a load transaction sets up a line, each step transaction emits one pixel.
// A pixel is presented in the cycle after its step transaction is accepted.
// Throughput: one command per cycle; the output register is refilled in the cycle it drains.
// Stalls come only from the pixel channel when the output register holds an untaken pixel.
// Reset (arst_n low) clears the line state, so steps give nothing until a load.
module line_rasterizer_unit #(
	parameter int unsigned COORD_W = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	rast_cmd_if.sink      cmd,
	rast_pix_if.source    pix
);

	logic             take;
	logic             emit;
	logic             out_free;
	logic             out_valid;
	rast_pkg::pixel_t core_pix;
	rast_pkg::pixel_t out_pix;

	// Accept a command whenever the output register can take a pixel
	assign cmd.ready = out_free;
	assign take      = cmd.valid && out_free;

	rast_core #(
		.COORD_W (COORD_W)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.opcode    (cmd.opcode),
		.x_start   (COORD_W'(cmd.x_start)),
		.y_start   (COORD_W'(cmd.y_start)),
		.x_end     (COORD_W'(cmd.x_end)),
		.y_end     (COORD_W'(cmd.y_end)),
		.pen_color (cmd.pen_color),
		.emit      (emit),
		.pix       (core_pix)
	);

	rast_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.din    (core_pix),
		.drain  (pix.ready),
		.valid  (out_valid),
		.free   (out_free),
		.dout   (out_pix)
	);

	// Present the held pixel
	assign pix.valid       = out_valid;
	assign pix.pixel_x     = out_pix.pixel_x;
	assign pix.pixel_y     = out_pix.pixel_y;
	assign pix.pixel_color = out_pix.pixel_color;
	assign pix.last_pixel  = out_pix.last_pixel;

endmodule

// ----- dv/rast_line_checker.sv -----
`timescale 1ns / 1ps

module rast_line_checker #(
	parameter int unsigned COORD_W = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	rast_cmd_if         cmd,
	rast_pix_if         pix,
	output int unsigned mismatches,
	output int unsigned pixels_owed,
	output int unsigned pixels_checked
);

	typedef logic [COORD_W-1:0] coord_t;

	// Shadow copy of the line being traced
	bit               line_active;
	bit               y_major;
	coord_t           major_at;
	coord_t           major_last;
	coord_t           minor_at;
	coord_t           major_len;
	coord_t           minor_len;
	logic [1:0]       minor_dir;
	logic [COORD_W:0] err_sum;
	logic             line_color;

	rast_pkg::pixel_t owed_q[$];
	int unsigned      fail_tally;
	int unsigned      checked_tally;

	// Pick the major axis, order the endpoints so it counts up, clear the error
	task automatic set_up_line(input logic [rast_pkg::PORT_W-1:0] xs_in,
			input logic [rast_pkg::PORT_W-1:0] ys_in,
			input logic [rast_pkg::PORT_W-1:0] xe_in,
			input logic [rast_pkg::PORT_W-1:0] ye_in,
			input logic color_in);
		coord_t xs, ys, xe, ye, dx, dy, maj0, maj1, min0, min1, tmp;
		xs = coord_t'(xs_in);
		ys = coord_t'(ys_in);
		xe = coord_t'(xe_in);
		ye = coord_t'(ye_in);
		dx = (xs >= xe) ? xs - xe : xe - xs;
		dy = (ys >= ye) ? ys - ye : ye - ys;
		if (dx >= dy) begin
			y_major   = 1'b0;
			maj0      = xs;
			maj1      = xe;
			min0      = ys;
			min1      = ye;
			major_len = dx;
			minor_len = dy;
		end else begin
			y_major   = 1'b1;
			maj0      = ys;
			maj1      = ye;
			min0      = xs;
			min1      = xe;
			major_len = dy;
			minor_len = dx;
		end
		if (maj0 > maj1) begin
			tmp  = maj0;
			maj0 = maj1;
			maj1 = tmp;
			tmp  = min0;
			min0 = min1;
			min1 = tmp;
		end
		major_at   = maj0;
		major_last = maj1;
		minor_at   = min0;
		if (min1 > min0)
			minor_dir = rast_pkg::DIR_UP;
		else if (min1 < min0)
			minor_dir = rast_pkg::DIR_DOWN;
		else
			minor_dir = rast_pkg::DIR_NONE;
		err_sum     = '0;
		line_color  = color_in;
		line_active = 1'b1;
	endtask

	// Emit the current pixel and move one unit along the major axis
	task automatic advance_line(output bit emitted, output rast_pkg::pixel_t px);
		bit at_end;
		emitted = 1'b0;
		px      = '0;
		if (!line_active)
			return;
		at_end = (major_at == major_last);
		if (y_major) begin
			px.pixel_x = rast_pkg::PORT_W'(minor_at);
			px.pixel_y = rast_pkg::PORT_W'(major_at);
		end else begin
			px.pixel_x = rast_pkg::PORT_W'(major_at);
			px.pixel_y = rast_pkg::PORT_W'(minor_at);
		end
		px.pixel_color = line_color;
		px.last_pixel  = at_end;
		emitted        = 1'b1;

		// Carry into the minor axis once the error passes the major span
		err_sum = err_sum + {1'b0, minor_len} + 1'b1;
		if (err_sum >= {1'b0, major_len} + 1'b1) begin
			if (minor_dir == rast_pkg::DIR_UP)
				minor_at = minor_at + 1'b1;
			else if (minor_dir == rast_pkg::DIR_DOWN)
				minor_at = minor_at - 1'b1;
			err_sum = err_sum - ({1'b0, major_len} + 1'b1);
		end

		if (at_end)
			line_active = 1'b0;
		else
			major_at = major_at + 1'b1;
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_tally++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// Retire pixels before predicting new ones, so an early pixel is never matched
	// against an expectation pushed in the same cycle
	always @(posedge clk or negedge arst_n) begin : watch
		rast_pkg::pixel_t want;
		rast_pkg::pixel_t made;
		bit               emitted;
		if (!arst_n) begin
			line_active   = 1'b0;
			y_major       = 1'b0;
			major_at      = '0;
			major_last    = '0;
			minor_at      = '0;
			major_len     = '0;
			minor_len     = '0;
			minor_dir     = rast_pkg::DIR_NONE;
			err_sum       = '0;
			line_color    = 1'b0;
			owed_q.delete();
			fail_tally    = 0;
			checked_tally = 0;
		end else begin
			if (pix.valid && pix.ready) begin
				if (owed_q.size() == 0) begin
					fail_tally++;
					$display("%0t: unexpected pixel x=%0d y=%0d with nothing owed",
						$time, pix.pixel_x, pix.pixel_y);
				end else begin
					want = owed_q.pop_front();
					check_field("pixel_x", 32'(want.pixel_x), 32'(pix.pixel_x));
					check_field("pixel_y", 32'(want.pixel_y), 32'(pix.pixel_y));
					check_field("pixel_color", 32'(want.pixel_color),
						32'(pix.pixel_color));
					check_field("last_pixel", 32'(want.last_pixel),
						32'(pix.last_pixel));
					checked_tally++;
				end
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd.opcode == rast_pkg::OPC_LOAD) begin
					set_up_line(cmd.x_start, cmd.y_start, cmd.x_end, cmd.y_end,
						cmd.pen_color);
				end else begin
					advance_line(emitted, made);
					if (emitted)
						owed_q.push_back(made);
				end
			end
		end
		mismatches     <= fail_tally;
		pixels_owed    <= $unsigned(owed_q.size());
		pixels_checked <= checked_tally;
	end

endmodule

// ----- dv/tb_line_rasterizer_unit.sv -----
`timescale 1ns / 1ps

module tb_line_rasterizer_unit;

	localparam int unsigned ITEM_TARGET  = 950;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned SETTLE_TICKS = 8;

	logic        clk;
	logic        arst_n;
	int unsigned cycle_count = 0;
	int unsigned loads_sent;
	int unsigned steps_sent;
	int unsigned drain_pauses;
	bit          no_gaps;
	int unsigned mismatches;
	int unsigned pixels_owed;
	int unsigned pixels_checked;

	rast_cmd_if cmd_ch ();
	rast_pix_if pix_ch ();

	line_rasterizer_unit #(
		.COORD_W(rast_pkg::PORT_W)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.pix   (pix_ch)
	);

	rast_line_checker #(
		.COORD_W(rast_pkg::PORT_W)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.pix           (pix_ch),
		.mismatches    (mismatches),
		.pixels_owed   (pixels_owed),
		.pixels_checked(pixels_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d pixels still owed", CYCLE_LIMIT, pixels_owed);
		$display("status: fail");
		$finish;
	end

	// Pixel sink: stall a random number of cycles before taking each pixel
	initial begin : pixel_sink
		int unsigned stall;
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				pix_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_ch.ready <= 1'b1;
			do @(posedge clk); while (!pix_ch.valid);
		end
	end

	// Send one command after a random gap; return at the edge that accepts it
	task automatic issue_command(input logic op, input logic [rast_pkg::PORT_W-1:0] xs,
			input logic [rast_pkg::PORT_W-1:0] ys, input logic [rast_pkg::PORT_W-1:0] xe,
			input logic [rast_pkg::PORT_W-1:0] ye, input logic color);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.opcode    <= op;
		cmd_ch.x_start   <= xs;
		cmd_ch.y_start   <= ys;
		cmd_ch.x_end     <= xe;
		cmd_ch.y_end     <= ye;
		cmd_ch.pen_color <= color;
		do @(posedge clk); while (!cmd_ch.ready);
		if (op == rast_pkg::OPC_LOAD)
			loads_sent++;
		else
			steps_sent++;
	endtask

	// Step with junk in the ignored fields
	task automatic issue_step();
		issue_command(rast_pkg::OPC_STEP, rast_pkg::PORT_W'($urandom),
			rast_pkg::PORT_W'($urandom), rast_pkg::PORT_W'($urandom),
			rast_pkg::PORT_W'($urandom), 1'($urandom));
	endtask

	task automatic trace_line(input logic [rast_pkg::PORT_W-1:0] xs,
			input logic [rast_pkg::PORT_W-1:0] ys,
			input logic [rast_pkg::PORT_W-1:0] xe,
			input logic [rast_pkg::PORT_W-1:0] ye,
			input logic color, input int unsigned step_total);
		issue_command(rast_pkg::OPC_LOAD, xs, ys, xe, ye, color);
		repeat (step_total) issue_step();
	endtask

	// Hold the sender until every owed pixel has been taken
	task automatic wait_for_drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pixels_owed != 0);
		drain_pauses++;
	endtask

	function automatic logic [rast_pkg::PORT_W-1:0] near_coord(
			input logic [rast_pkg::PORT_W-1:0] base, input int reach);
		int pos;
		pos = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
		if (pos < 0)
			pos = 0;
		if (pos > 255)
			pos = 255;
		return rast_pkg::PORT_W'(pos);
	endfunction

	function automatic int unsigned span_of(input logic [rast_pkg::PORT_W-1:0] a,
			input logic [rast_pkg::PORT_W-1:0] b);
		return (a >= b) ? 32'(a - b) : 32'(b - a);
	endfunction

	initial begin : stimulus
		logic [rast_pkg::PORT_W-1:0] xs, ys, xe, ye;
		int unsigned                 n_steps;
		int unsigned                 shape;
		loads_sent       = 0;
		steps_sent       = 0;
		drain_pauses     = 0;
		no_gaps          = 1'b0;
		arst_n           <= 1'b0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.opcode    <= rast_pkg::OPC_STEP;
		cmd_ch.x_start   <= '0;
		cmd_ch.y_start   <= '0;
		cmd_ch.x_end     <= '0;
		cmd_ch.y_end     <= '0;
		cmd_ch.pen_color <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle step, single point, swapped and steep lines, load while busy
		issue_step();
		trace_line(8'd7, 8'd7, 8'd7, 8'd7, 1'b1, 2);
		trace_line(8'd255, 8'd0, 8'd251, 8'd2, 1'b0, 5);
		trace_line(8'd0, 8'd255, 8'd2, 8'd250, 1'b1, 2);
		trace_line(8'd3, 8'd3, 8'd0, 8'd0, 1'b1, 4);
		trace_line(8'd10, 8'd20, 8'd10, 8'd23, 1'b0, 4);
		wait_for_drain();

		// Random: mostly whole lines, some cut short, overrun, or plain noise
		while (loads_sent + steps_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 15) == 0) begin
				wait_for_drain();
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			shape = $urandom_range(0, 19);
			if (shape == 0) begin
				issue_step();
			end else if (shape == 1) begin
				issue_command(rast_pkg::OPC_LOAD, rast_pkg::PORT_W'($urandom),
					rast_pkg::PORT_W'($urandom), rast_pkg::PORT_W'($urandom),
					rast_pkg::PORT_W'($urandom), 1'($urandom));
			end else begin
				xs = rast_pkg::PORT_W'($urandom);
				ys = rast_pkg::PORT_W'($urandom);
				if ($urandom_range(0, 9) == 0)
					xs = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				if ($urandom_range(0, 9) == 0)
					ys = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				if ($urandom_range(0, 39) == 0) begin
					xe = rast_pkg::PORT_W'($urandom);
					ye = rast_pkg::PORT_W'($urandom);
				end else begin
					xe = near_coord(xs, 12);
					ye = near_coord(ys, 12);
				end
				n_steps = span_of(xs, xe);
				if (span_of(ys, ye) > n_steps)
					n_steps = span_of(ys, ye);
				n_steps++;
				case ($urandom_range(0, 7))
					0: n_steps = $urandom_range(1, n_steps);
					1: n_steps = n_steps + $urandom_range(1, 3);
					default: ;
				endcase
				// Keep the run near its item budget
				if (n_steps > ITEM_TARGET - loads_sent - steps_sent)
					n_steps = ITEM_TARGET - loads_sent - steps_sent;
				trace_line(xs, ys, xe, ye, 1'($urandom), n_steps);
			end
		end

		// Let the last pixels out, then watch for strays
		wait_for_drain();
		repeat (SETTLE_TICKS) @(posedge clk);
		$display("Ran %0d line loads and %0d step commands; %0d pixels matched, %0d drain pauses",
			loads_sent, steps_sent, pixels_checked, drain_pauses);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule
